// ===== hw/rtl/asrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the audio sample rate converter.
// No dependencies; imported by every module of the block.
package asrc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int PHASE_W   = 23;
   localparam int SUM_W     = 34;
   localparam int W0_W      = 23;
   localparam int W1_W      = 17;
   localparam int STEP_W    = 21;
   localparam int BUDGET_W  = 24;
   localparam int TAIL_W    = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam int MAX_RATIO_DEF = 32;

   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);
   localparam logic [15:0]        FRAC_MAX  = 16'hFFFF;
   localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(65536);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL   = 3'd5;

   // conversion modes
   localparam logic [1:0] MODE_NEAR = 2'd0;
   localparam logic [1:0] MODE_LERP = 2'd1;
   localparam logic [1:0] MODE_BOX  = 2'd2;

   // width conversion codes
   localparam logic [1:0] WC_NONE  = 2'd0;
   localparam logic [1:0] WC_8TO16 = 2'd1;
   localparam logic [1:0] WC_16TO8 = 2'd2;

   typedef logic [2:0] asrc_op_type;

   localparam asrc_op_type OP_NEAR      = 3'd0;
   localparam asrc_op_type OP_LERP      = 3'd1;
   localparam asrc_op_type OP_BOX_ADD   = 3'd2;
   localparam asrc_op_type OP_BOX_CARRY = 3'd3;
   localparam asrc_op_type OP_BOX_LAST  = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
      logic                       final_frame;
   } asrc_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       run_end;
   } asrc_rsp_type;

   // control from the sequencer to both lanes
   typedef struct packed {
      logic              load;
      logic              mul;
      logic              acc;
      logic              commit;
      logic              clear;
      asrc_op_type       op;
      logic [1:0]        wc;
      logic [W0_W-1:0]   w0;
      logic [W1_W-1:0]   w1;
   } asrc_lane_ctl_type;

endpackage

// ===== hw/rtl/asrc_lane.sv =====
`timescale 1ns / 1ps
// One channel datapath: sample capture, weighted products, box sum, scaling.
// Depends on asrc_pkg.
module asrc_lane import asrc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  asrc_lane_ctl_type          ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SAMPLE_W-1:0] result
);

   logic signed [SAMPLE_W-1:0] cur_ff, cur_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SUM_W-1:0]    p0_ff, p0_in;
   logic signed [SUM_W-1:0]    p1_ff, p1_in;

   logic signed [SAMPLE_W-1:0]         x0;
   logic signed [W0_W+SAMPLE_W-1:0]    mul0;
   logic signed [W1_W+SAMPLE_W-1:0]    mul1;
   logic signed [SUM_W-1:0]            total;
   logic signed [SAMPLE_W-1:0]         scaled;
   logic signed [SAMPLE_W-1:0]         near;

   assign x0   = (ctl.op == OP_LERP) ? prev_ff : cur_ff;
   assign mul0 = $signed(ctl.w0) * x0;
   assign mul1 = $signed(ctl.w1) * cur_ff;
   assign total = ((ctl.op == OP_LERP) ? p1_ff : sum_ff) + p0_ff;

   always_comb begin
      unique case (ctl.wc)
         WC_8TO16: begin
            scaled = total[23:8];
            near   = {cur_ff[7:0], 8'h00};
         end
         WC_16TO8: begin
            scaled = {{6{total[SUM_W-1]}}, total[33:24]};
            near   = {{8{cur_ff[15]}}, cur_ff[15:8]};
         end
         default: begin
            scaled = total[31:16];
            near   = cur_ff;
         end
      endcase
   end

   assign result = (ctl.op == OP_NEAR) ? near : scaled;

   always_comb begin
      cur_in  = cur_ff;
      prev_in = prev_ff;
      sum_in  = sum_ff;
      p0_in   = p0_ff;
      p1_in   = p1_ff;
      if (ctl.load) begin
         cur_in = (ctl.wc == WC_8TO16) ? {{8{sample[7]}}, sample[7:0]} : sample;
      end
      if (ctl.mul) begin
         p0_in = mul0[SUM_W-1:0];
         p1_in = SUM_W'(mul1);
      end
      if (ctl.acc) begin
         case (ctl.op)
            OP_BOX_CARRY: sum_in = p1_ff;
            OP_BOX_ADD:   sum_in = total;
            default:      sum_in = sum_ff;
         endcase
      end
      if (ctl.commit) begin
         prev_in = cur_ff;
      end
      if (ctl.clear) begin
         prev_in = '0;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         sum_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
   end

endmodule

// ===== hw/rtl/asrc_merge.sv =====
`timescale 1ns / 1ps
// Output stage: joins the two lane results into one response word and holds it.
// Depends on asrc_pkg.
module asrc_merge import asrc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] left,
   input  logic signed [SAMPLE_W-1:0] right,
   input  logic                       run_end,
   input  logic                       stereo,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output asrc_rsp_type               rsp_data,
   output logic                       space
);

   logic         valid_ff, valid_in;
   asrc_rsp_type data_ff, data_in;

   assign space = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in          = 1'b1;
         data_in.out_left  = left;
         data_in.out_right = stereo ? right : '0;
         data_in.run_end   = run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/audio_sample_rate_converter.sv =====
`timescale 1ns / 1ps
// Sample rate converter top: configuration registers, phase sequencer, two lanes.
// Depends on asrc_pkg, asrc_lane and asrc_merge.
//
// Usage:
// - csr_*: write a register by index while the block is idle (csr_ready high).
// - req_*: one PCM frame per word; req_stall is high while a frame is in work.
// - rsp_*: output words; run_end marks the last word a frame produced.
// Steps per frame, after the frame is accepted:
// - nearest mode: start, then one emit per output word (up to MaxRatio words).
// - linear mode: start, then a multiply and a sum per interpolated word,
//   then one copy step per tail copy.
// - box mode: start, multiply, emit, end; one word or none.
// The lanes work left and right in parallel; output words leave through a
// one-word register, so the next frame is taken while the last word waits.
// A stalled receiver holds the sequencer at its next output word.
// Reset (synchronous) restores default registers and clears the sound state;
// a final frame does the same for the sound state once processed.
module audio_sample_rate_converter import asrc_pkg::*; #(
   parameter int MaxRatio = MAX_RATIO_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  asrc_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output asrc_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   localparam int KW = $clog2(MaxRatio + 1);
   localparam logic [KW:0]     MAX_CNT  = (KW+1)'(MaxRatio);
   localparam logic [KW-1:0]   MAX_TAIL = KW'(MaxRatio);
   localparam logic [TAIL_W-1:0] MAX_TCFG = TAIL_W'(MaxRatio);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_END   = 3'd5;

   // configuration
   logic [1:0]          mode_ff, mode_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          wc_ff, wc_in;
   logic                stereo_ff, stereo_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [TAIL_W-1:0]   tcfg_ff, tcfg_in;

   // sequencer
   logic [2:0]          state_ff, state_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [BUDGET_W-1:0] emitted_ff, emitted_in;
   logic                have_prev_ff, have_prev_in;
   logic                fin_ff, fin_in;
   asrc_op_type         op_ff, op_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [KW-1:0]       tcnt_ff, tcnt_in;

   logic                req_take;
   logic                csr_take;
   logic                lin;
   logic [PHASE_W-1:0]  phase_step;
   logic [PHASE_W-1:0]  phase_adj;
   logic                phase_hi;
   logic                step_hi;
   logic [KW:0]         k_inc;
   logic [BUDGET_W-1:0] emit_inc;
   logic                more;
   logic [KW-1:0]       tail_cap;
   logic                tail_go;
   logic                out_load;
   logic                out_end;
   logic                space;

   asrc_lane_ctl_type           ctl;
   logic signed [SAMPLE_W-1:0]  res_left;
   logic signed [SAMPLE_W-1:0]  res_right;
   logic signed [SAMPLE_W-1:0]  right_sample;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;

   assign lin        = (mode_ff == MODE_LERP);
   assign phase_step = phase_ff + {2'b00, step_ff};
   assign phase_hi   = |phase_ff[PHASE_W-1:16];
   assign step_hi    = |phase_step[PHASE_W-1:16];
   assign phase_adj  = step_hi ? (phase_step - PHASE_ONE) : phase_step;
   assign k_inc      = {1'b0, k_ff} + 1'b1;
   assign emit_inc   = emitted_ff + 1'b1;
   assign more       = !step_hi && (k_inc < MAX_CNT) && (emit_inc < budget_ff);
   assign tail_cap   = (tcfg_ff > MAX_TCFG) ? MAX_TAIL : tcfg_ff[KW-1:0];
   assign tail_go    = lin && fin_ff && (tail_cap != '0);

   // configuration writes
   always_comb begin
      mode_in   = mode_ff;
      step_in   = step_ff;
      wc_in     = wc_ff;
      stereo_in = stereo_ff;
      budget_in = budget_ff;
      tcfg_in   = tcfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            CSR_MODE:   mode_in   = csr_data[1:0];
            CSR_STEP:   step_in   = csr_data[STEP_W-1:0];
            CSR_WIDTH:  wc_in     = csr_data[1:0];
            CSR_STEREO: stereo_in = csr_data[0];
            CSR_BUDGET: budget_in = csr_data[BUDGET_W-1:0];
            CSR_TAIL:   tcfg_in   = csr_data[TAIL_W-1:0];
            default: ;
         endcase
      end
   end

   // lane weights follow the current op, phase and step
   always_comb begin
      ctl        = '0;
      ctl.op     = op_ff;
      ctl.wc     = wc_ff;
      ctl.load   = req_take;
      ctl.mul    = (state_ff == S_MUL);
      case (op_ff)
         OP_LERP: begin
            ctl.w0 = {7'd0, FRAC_MAX - phase_ff[15:0]};
            ctl.w1 = {1'b0, phase_ff[15:0]};
         end
         OP_BOX_LAST: ctl.w0 = {7'd0, FRAC_MAX - phase_ff[15:0]};
         OP_BOX_ADD:  ctl.w0 = {2'b00, step_ff};
         OP_BOX_CARRY: begin
            ctl.w0 = {2'b00, step_ff} - {7'd0, phase_ff[15:0]};
            ctl.w1 = {1'b0, phase_ff[15:0]};
         end
         default: ;
      endcase
      ctl.acc    = (state_ff == S_EMIT) && (op_ff == OP_BOX_ADD || space);
      ctl.commit = (state_ff == S_END);
      ctl.clear  = (state_ff == S_END) && fin_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      emitted_in   = emitted_ff;
      have_prev_in = have_prev_ff;
      fin_in       = fin_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      tcnt_in      = tcnt_ff;
      out_load     = 1'b0;
      out_end      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               fin_in   = req_data.final_frame;
               state_in = S_START;
            end
         end
         S_START: begin
            op_in    = OP_NEAR;
            tcnt_in  = tail_cap;
            state_in = tail_go ? S_TAIL : S_END;
            if (mode_ff == MODE_BOX) begin
               state_in = S_MUL;
               if (fin_ff) begin
                  op_in = OP_BOX_LAST;
               end else if (step_hi) begin
                  op_in    = OP_BOX_CARRY;
                  phase_in = {7'd0, phase_step[15:0]};
               end else begin
                  op_in    = OP_BOX_ADD;
                  phase_in = phase_step;
               end
            end else if (!lin || have_prev_ff) begin
               if (phase_hi) begin
                  phase_in = phase_ff - PHASE_ONE;
               end else if (emitted_ff < budget_ff) begin
                  k_in     = '0;
                  op_in    = lin ? OP_LERP : OP_NEAR;
                  state_in = lin ? S_MUL : S_EMIT;
               end
            end
         end
         S_MUL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            case (op_ff) inside
               OP_BOX_ADD: state_in = S_END;
               OP_BOX_CARRY, OP_BOX_LAST: begin
                  if (space) begin
                     out_load = 1'b1;
                     out_end  = 1'b1;
                     state_in = S_END;
                  end
               end
               default: begin
                  if (space) begin
                     out_load   = 1'b1;
                     out_end    = !more && !tail_go;
                     emitted_in = emit_inc;
                     k_in       = k_inc[KW-1:0];
                     if (more) begin
                        phase_in = phase_step;
                        state_in = lin ? S_MUL : S_EMIT;
                     end else begin
                        phase_in = phase_adj;
                        op_in    = OP_NEAR;
                        tcnt_in  = tail_cap;
                        state_in = tail_go ? S_TAIL : S_END;
                     end
                  end
               end
            endcase
         end
         S_TAIL: begin
            if (space) begin
               out_load = 1'b1;
               out_end  = (tcnt_ff == KW'(1));
               tcnt_in  = tcnt_ff - 1'b1;
               if (tcnt_ff == KW'(1)) begin
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            have_prev_in = 1'b1;
            if (fin_ff) begin
               phase_in     = '0;
               emitted_in   = '0;
               have_prev_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NEAR;
         step_ff      <= STEP_RST;
         wc_ff        <= WC_NONE;
         stereo_ff    <= 1'b0;
         budget_ff    <= '0;
         tcfg_ff      <= '0;
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         emitted_ff   <= '0;
         have_prev_ff <= 1'b0;
         fin_ff       <= 1'b0;
         op_ff        <= OP_NEAR;
         k_ff         <= '0;
         tcnt_ff      <= '0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         wc_ff        <= wc_in;
         stereo_ff    <= stereo_in;
         budget_ff    <= budget_in;
         tcfg_ff      <= tcfg_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         emitted_ff   <= emitted_in;
         have_prev_ff <= have_prev_in;
         fin_ff       <= fin_in;
         op_ff        <= op_in;
         k_ff         <= k_in;
         tcnt_ff      <= tcnt_in;
      end
   end

   assign right_sample = stereo_ff ? req_data.sample_right : '0;

   asrc_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_data.sample_left),
      .result (res_left)
   );

   asrc_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (right_sample),
      .result (res_right)
   );

   asrc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .left      (res_left),
      .right     (res_right),
      .run_end   (out_end),
      .stereo    (stereo_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space     (space)
   );

endmodule
